/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the combination generator.
// Depends on nothing; users supply clk and rst_n in the scope that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while reset is asserted.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, sampled on clk, off while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_SAME(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/lcg_pkg.sv */
// Shared widths, register codes and beat layout of the combination generator.
// Depends on nothing; used by the top module and lcg_sat_unit.
package lcg_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int INDEX_W     = 6;
  localparam int POS_W       = 4;
  localparam int SET_W       = 7;
  localparam int PICK_W      = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_SIZE   = 1'b0,
    REG_PICK_COUNT = 1'b1
  } cfg_reg_t;

  // One result beat as held in the output register.
  typedef struct packed {
    logic [INDEX_W-1:0] index_value;
    logic [POS_W-1:0]   position;
    logic               last_in_combination;
    logic               final_combination;
    logic               exhausted;
  } out_beat_t;

endpackage

/* sv/lexicographic_combination_generator_top.sv */
// Lexicographic combination generator: each request beat (restart in bit 0 of in_tdata)
// yields one combination of r indices out of 0..n-1 as r result beats, or one exhausted
// beat. All work runs through one index RAM (registered read, one slot per access) and
// one shared saturation comparator. A restart fills the slots, checks them for the final
// combination and emits the beats; an advance first scans from the rightmost slot down,
// then fills, checks and emits; each beat waits until the sink is ready. An exhausted
// request yields its one beat directly, or after the advance scan finds no slot that can still grow.
// The block takes no request while one is in work.
// Depends on lcg_pkg, lcg_ram, lcg_sat_unit and assert_macros.svh.
`include "assert_macros.svh"
module lexicographic_combination_generator_top #(
  parameter int MAX_SET  = 64,
  parameter int MAX_PICK = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lcg_pkg::IN_TDATA_W-1:0]   in_tdata,   // [0] restart, [7:1] zero
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lcg_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [5:0] index_value,
                                                       // [9:6] position, [15:10] zero
  output logic                             out_tlast,  // last_in_combination
  output logic [lcg_pkg::OUT_TUSER_W-1:0]  out_tuser,  // [0] final_combination,
                                                       // [1] exhausted
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lcg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lcg_pkg::*;

  localparam int IDX_W  = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
  localparam int SLOT_W = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
  localparam int CMP_W  = ((IDX_W > SET_W) ? IDX_W : SET_W) + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FILL,
    ST_CHK_RD,
    ST_CHK_USE,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  state_t              state_r,   state_nxt;
  logic [SLOT_W-1:0]   slot_r,    slot_nxt;
  logic [IDX_W-1:0]    run_r,     run_nxt;
  logic                all_sat_r, all_sat_nxt;
  logic                final_r,   final_nxt;
  logic                done_r,    done_nxt;
  logic [SET_W-1:0]    set_r,     set_nxt;
  logic [PICK_W-1:0]   pick_r,    pick_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_beat_t           out_beat_r,  out_beat_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_rdata;
  logic                slot_sat;
  logic                usable;
  logic                last_slot;
  logic                out_free;
  logic                in_beat;

  // Index store, addressed by the current slot for both ports.
  assign ram_we = (state_r == ST_FILL);

  lcg_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_PICK)
  ) u_index_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (run_r),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  // One comparator serves both the advance scan and the final check.
  lcg_sat_unit #(
    .IDX_W  (IDX_W),
    .SLOT_W (SLOT_W)
  ) u_sat (
    .value      (ram_rdata),
    .slot       (slot_r),
    .set_size   (set_r),
    .pick_count (pick_r),
    .saturated  (slot_sat)
  );

  // Handshakes and shared decodes.
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign last_slot = ((SET_W'(slot_r) + SET_W'(1)) == SET_W'(pick_r));
  assign usable    = (set_r != '0) && (pick_r != '0) &&
                     (int'(set_r) <= MAX_SET) && (int'(pick_r) <= MAX_PICK) &&
                     (SET_W'(pick_r) <= set_r);

  // Sequencer next state.
  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    run_nxt       = run_r;
    all_sat_nxt   = all_sat_r;
    final_nxt     = final_r;
    done_nxt      = done_r;
    set_nxt       = set_r;
    pick_nxt      = pick_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_beat_nxt  = out_beat_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SET_SIZE:   set_nxt  = SET_W'(cfg_data);
        REG_PICK_COUNT: pick_nxt = PICK_W'(cfg_data);
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          if (!usable) begin
            done_nxt  = 1'b1;
            state_nxt = ST_EXH;
          end else if (in_tdata[0]) begin
            // Restart loads 0..r-1 starting at slot zero.
            done_nxt  = 1'b0;
            slot_nxt  = '0;
            run_nxt   = '0;
            state_nxt = ST_FILL;
          end else if (done_r) begin
            state_nxt = ST_EXH;
          end else begin
            slot_nxt  = SLOT_W'(pick_r - PICK_W'(1));
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_EXH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = '{index_value: '0, position: '0, last_in_combination: 1'b1,
                            final_combination: 1'b0, exhausted: 1'b1};
          state_nxt     = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        // Rightmost slot that can still grow starts the refill.
        if (!slot_sat) begin
          run_nxt   = ram_rdata + IDX_W'(1);
          state_nxt = ST_FILL;
        end else if (slot_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = ST_EXH;
        end else begin
          slot_nxt  = slot_r - SLOT_W'(1);
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_FILL: begin
        // Each later slot holds one more than the slot before it.
        run_nxt = run_r + IDX_W'(1);
        if (last_slot) begin
          slot_nxt    = '0;
          all_sat_nxt = 1'b1;
          state_nxt   = ST_CHK_RD;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end
      ST_CHK_RD: begin
        state_nxt = ST_CHK_USE;
      end
      ST_CHK_USE: begin
        // The combination is final when every slot is saturated.
        all_sat_nxt = all_sat_r && slot_sat;
        if (last_slot) begin
          final_nxt = all_sat_r && slot_sat;
          if (all_sat_r && slot_sat) begin
            done_nxt = 1'b1;
          end
          slot_nxt  = '0;
          state_nxt = ST_EMIT_RD;
        end else begin
          slot_nxt  = slot_r + SLOT_W'(1);
          state_nxt = ST_CHK_RD;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        // Read data stays stable while the output register is still full.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = '{index_value: INDEX_W'(ram_rdata), position: POS_W'(slot_r),
                            last_in_combination: last_slot,
                            final_combination: final_r, exhausted: 1'b0};
          if (last_slot) begin
            state_nxt = ST_IDLE;
          end else begin
            slot_nxt  = slot_r + SLOT_W'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      done_r      <= 1'b1;
      set_r       <= SET_W'(1);
      pick_r      <= PICK_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      set_r       <= set_nxt;
      pick_r      <= pick_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r     <= slot_nxt;
    run_r      <= run_nxt;
    all_sat_r  <= all_sat_nxt;
    final_r    <= final_nxt;
    out_beat_r <= out_beat_nxt;
  end

  // Result port packing.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - INDEX_W - POS_W){1'b0}},
                       out_beat_r.position, out_beat_r.index_value};
  assign out_tlast  = out_beat_r.last_in_combination;
  assign out_tuser  = {out_beat_r.exhausted, out_beat_r.final_combination};

  // Checks on the sequencer.
  `ASSERT_NEXT(a_busy_after_request, in_tvalid && in_tready, !in_tready)
  `ASSERT_SAME(a_exhausted_beat_shape, out_tvalid && out_tuser[1],
               out_tlast && (out_tdata == '0) && !out_tuser[0])
  `ASSERT_SAME(a_fill_below_set_size, ram_we, CMP_W'(run_r) < CMP_W'(set_r))

endmodule

/* sv/lcg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* sv/lcg_sat_unit.sv */
// Shared saturation compare: a slot is saturated when value >= n - r + slot.
// Depends on lcg_pkg for the configuration register widths.
module lcg_sat_unit #(
  parameter int IDX_W  = 6,
  parameter int SLOT_W = 4
) (
  input  logic [IDX_W-1:0]          value,
  input  logic [SLOT_W-1:0]         slot,
  input  logic [lcg_pkg::SET_W-1:0]  set_size,
  input  logic [lcg_pkg::PICK_W-1:0] pick_count,
  output logic                      saturated
);
  import lcg_pkg::*;

  localparam int W0    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int CMP_W = ((W0 > SET_W) ? W0 : SET_W) + 2;

  logic [CMP_W-1:0] lhs;
  logic [CMP_W-1:0] rhs;

  // Rearranged as value + r >= n + slot so that nothing goes negative.
  assign lhs       = CMP_W'(value) + CMP_W'(pick_count);
  assign rhs       = CMP_W'(set_size) + CMP_W'(slot);
  assign saturated = (lhs >= rhs);

endmodule

/* sim/lcg_result_checker.sv */
// Result checker for the combination generator: predicts the beats of every request
// and compares them with the result stream. Depends on lcg_pkg.
module lcg_result_checker #(
  parameter int MAX_SET  = 64,
  parameter int MAX_PICK = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [lcg_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [lcg_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             out_tlast,
  input  logic [lcg_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [lcg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               mismatches,
  output int                               beats_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcg_pkg::*;

  // Mirror of the generator state and its configuration.
  int        set_n;
  int        pick_r;
  int        combo_slot [MAX_PICK];
  bit        combos_done;
  out_beat_t expected_beats [$];
  int        beat_count;

  task report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: result beat %0d, %s: got %0d, want %0d",
             $realtime, beat_count, what, got, want);
    mismatches++;
  endtask

  // A slot is saturated once it holds its largest value for this n and r.
  function bit slot_full(input int k);
    return combo_slot[k] >= set_n - pick_r + k;
  endfunction

  // Appends one beat at the tail of the expected stream.
  function void queue_beat(input out_beat_t beat);
    expected_beats.insert(expected_beats.size(), beat);
  endfunction

  function void push_exhausted();
    out_beat_t beat;
    beat = '0;
    beat.last_in_combination = 1'b1;
    beat.exhausted           = 1'b1;
    queue_beat(beat);
  endfunction

  // Advances (or reloads) the combination and queues the beats of one request.
  function void predict_request(input bit restart);
    int        grow;
    int        k;
    bit        last_combo;
    out_beat_t beat;
    if (set_n < 1 || pick_r < 1 || set_n > MAX_SET || pick_r > MAX_PICK ||
        pick_r > set_n) begin
      combos_done = 1'b1;
      push_exhausted();
      return;
    end
    if (restart) begin
      for (k = 0; k < pick_r; k++) combo_slot[k] = k;
      combos_done = 1'b0;
    end else begin
      if (combos_done) begin
        push_exhausted();
        return;
      end
      // Find the rightmost slot that can still grow.
      grow = pick_r;
      while (grow > 0 && slot_full(grow - 1)) grow--;
      if (grow == 0) begin
        combos_done = 1'b1;
        push_exhausted();
        return;
      end
      grow--;
      combo_slot[grow]++;
      for (k = grow + 1; k < pick_r; k++) combo_slot[k] = combo_slot[k-1] + 1;
    end
    last_combo = 1'b1;
    for (k = 0; k < pick_r; k++) begin
      if (!slot_full(k)) last_combo = 1'b0;
    end
    if (last_combo) combos_done = 1'b1;
    for (k = 0; k < pick_r; k++) begin
      beat.index_value         = INDEX_W'(combo_slot[k]);
      beat.position            = POS_W'(k);
      beat.last_in_combination = (k == pick_r - 1);
      beat.final_combination   = last_combo;
      beat.exhausted           = 1'b0;
      queue_beat(beat);
    end
  endfunction

  // Follow register writes and requests, then check each result beat in order.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      set_n       = 1;
      pick_r      = 1;
      combos_done = 1'b1;
      mismatches  = 0;
      beat_count  = 0;
      for (int k = 0; k < MAX_PICK; k++) combo_slot[k] = 0;
      expected_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SET_SIZE) set_n = int'(cfg_data);
        else pick_r = int'(cfg_data[PICK_W-1:0]);
      end
      if (in_tvalid && in_tready) predict_request(in_tdata[0]);
      if (out_tvalid && out_tready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("beat with nothing expected, index",
                          int'(out_tdata[INDEX_W-1:0]), 0);
        end else begin
          want = expected_beats.pop_front();
          if (out_tdata[INDEX_W-1:0] != want.index_value)
            report_mismatch("index_value", int'(out_tdata[INDEX_W-1:0]),
                            int'(want.index_value));
          if (out_tdata[INDEX_W+POS_W-1:INDEX_W] != want.position)
            report_mismatch("position", int'(out_tdata[INDEX_W+POS_W-1:INDEX_W]),
                            int'(want.position));
          if (out_tdata[OUT_TDATA_W-1:INDEX_W+POS_W] != '0)
            report_mismatch("tdata padding",
                            int'(out_tdata[OUT_TDATA_W-1:INDEX_W+POS_W]), 0);
          if (out_tlast != want.last_in_combination)
            report_mismatch("last_in_combination", int'(out_tlast),
                            int'(want.last_in_combination));
          if (out_tuser[0] != want.final_combination)
            report_mismatch("final_combination", int'(out_tuser[0]),
                            int'(want.final_combination));
          if (out_tuser[1] != want.exhausted)
            report_mismatch("exhausted", int'(out_tuser[1]), int'(want.exhausted));
        end
        beat_count++;
      end
    end
    beats_pending <= expected_beats.size();
  end

endmodule

/* sim/lexicographic_combination_generator_top_tb.sv */
// Testbench top for the combination generator: clock, reset, request and register
// stimulus, random sink stalls and the verdict. Depends on lcg_pkg, the block
// and lcg_result_checker.
module lexicographic_combination_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcg_pkg::*;

  localparam int MAX_SET      = 64;
  localparam int MAX_PICK     = 16;
  localparam int RANDOM_ITEMS = 350;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     mismatches;
  int                     beats_pending;

  // Stimulus bookkeeping: current n and r, and how many slots have been loaded.
  int cur_n;
  int cur_r;
  int loaded_slots;
  bit no_idle;
  int stall_cycles;

  lexicographic_combination_generator_top #(
    .MAX_SET (MAX_SET),
    .MAX_PICK(MAX_PICK)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lcg_result_checker #(
    .MAX_SET (MAX_SET),
    .MAX_PICK(MAX_PICK)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .beats_pending(beats_pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  // Waits until every predicted beat has been taken from the result channel.
  task wait_drained();
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
  endtask

  // Sends one request beat. A plain request that would scan slots never
  // loaded since reset is turned into a restart. Before the first usable
  // restart every plain request is exhausted, so nothing is scanned then.
  task issue_request(input bit restart);
    int gap;
    if (!restart && loaded_slots != 0 && cur_r <= cur_n && cur_r > loaded_slots)
      restart = 1'b1;
    if (restart && cur_r <= cur_n && cur_r > loaded_slots) loaded_slots = cur_r;
    gap = draw_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-1){1'b0}}, restart};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task write_reg(input cfg_reg_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Register writes happen only once the block has delivered all results.
  task program_regs(input int n, input int r, input bit wr_n, input bit wr_r);
    in_tvalid <= 1'b0;
    wait_drained();
    if (wr_n) begin
      write_reg(REG_SET_SIZE, n);
      cur_n = n;
    end
    if (wr_r) begin
      write_reg(REG_PICK_COUNT, r);
      cur_r = r;
    end
    cfg_valid <= 1'b0;
  endtask

  // Result sink with random stalls drawn per beat.
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Watchdog: too long without any beat or register write ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Main stimulus.
  initial begin
    int  items_done;
    int  phase;
    int  run_len;
    int  kind;
    int  n;
    int  r;
    bit  both;
    bit  restart;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_SET_SIZE;
    cfg_data     = '0;
    cur_n        = 1;
    cur_r        = 1;
    loaded_slots = 0;
    no_idle      = 1'b0;
    items_done   = 0;
    phase        = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A request before any restart is exhausted.
    issue_request(1'b0);
    // Smallest set: one combination, then exhausted.
    program_regs(1, 1, 1'b1, 1'b1);
    issue_request(1'b1);
    issue_request(1'b0);
    // r above n: every request is exhausted, restart or not.
    program_regs(3, 5, 1'b1, 1'b1);
    issue_request(1'b1);
    issue_request(1'b0);
    // Full walk of 4 choose 2, one request past the end, then a restart.
    program_regs(4, 2, 1'b1, 1'b1);
    issue_request(1'b1);
    repeat (6) issue_request(1'b0);
    issue_request(1'b1);
    // Widest pick, then a smaller set while the enumeration is under way.
    program_regs(64, 16, 1'b1, 1'b1);
    issue_request(1'b1);
    issue_request(1'b0);
    issue_request(1'b0);
    program_regs(17, 16, 1'b1, 1'b0);
    issue_request(1'b0);
    issue_request(1'b0);
    issue_request(1'b1);

    // Random part: phases of one setting each, mostly restart then advances.
    while (items_done < RANDOM_ITEMS) begin
      both = 1'b1;
      case (phase)
        0: begin
          n = 64;  r = 1;  run_len = 66;
        end
        1: begin
          n = 64;  r = 16; run_len = 5;
        end
        2: begin
          n = 16;  r = 16; run_len = 3;
        end
        default: begin
          kind = $urandom_range(0, 9);
          if (kind < 5) begin
            n       = $urandom_range(1, 8);
            r       = $urandom_range(1, n + 1);
            run_len = $urandom_range(4, 30);
          end else begin
            n       = $urandom_range(1, 64);
            r       = $urandom_range(1, 16);
            run_len = $urandom_range(2, 12);
          end
          both = ($urandom_range(0, 3) != 0);
          if (!both && $urandom_range(0, 1) == 1) begin
            // Change only r; keep n as it is.
            program_regs(cur_n, r, 1'b0, 1'b1);
          end else if (!both) begin
            program_regs(n, cur_r, 1'b1, 1'b0);
          end
        end
      endcase
      if (both) program_regs(n, r, 1'b1, 1'b1);
      no_idle = (phase > 0 && $urandom_range(0, 3) == 0);
      for (int j = 0; j < run_len && items_done < RANDOM_ITEMS; j++) begin
        if (j == 0) restart = both ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 3) == 0);
        else restart = ($urandom_range(0, 14) == 0);
        issue_request(restart);
        items_done++;
        // Now and then let every outstanding result drain before going on.
        if ($urandom_range(0, 29) == 0) begin
          in_tvalid <= 1'b0;
          wait_drained();
        end
      end
      phase++;
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
